// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RSD_ASSERT_CR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Same, on the default clk_i / rst_ni pair.
`define RSD_ASSERT(lbl, prop) \
  `RSD_ASSERT_CR(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/rsd_pkg.sv =====
// Shared types and constants of the rolling standard deviation block.
package rsd_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned WIN_MAX   = 64;
  localparam int unsigned ADDR_W    = $clog2(WIN_MAX);
  localparam int unsigned N_W       = $clog2(WIN_MAX + 1);
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned SUM_W     = SAMPLE_W + N_W - 1;
  localparam int unsigned SQ_W      = 2 * SAMPLE_W + N_W - 2;
  localparam int unsigned DEV_W     = SQ_W + N_W;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned RAD_W     = DEV_W + FRAC_W;
  localparam int unsigned ROOT_W    = RAD_W / 2;
  localparam int unsigned CNT_W     = $clog2(ROOT_W);
  localparam int unsigned STD_W     = 23;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(20);
  localparam logic [STD_W-1:0] STD_MAX   = {STD_W{1'b1}};

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [N_W-1:0]      n;
    logic                full;
  } item_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_WRITE = 8'b0000_0010,
    ST_SUM   = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_SUB   = 8'b0001_0000,
    ST_SQRT  = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } back_state_e;

endpackage

// ===== rtl/rolling_standard_deviation.sv =====
// For window length N the back end writes the sample into the ring, reads the N newest
// entries for the sums, multiplies, subtracts, then runs a restoring square root and a
// divide by N, one bit a cycle; it takes no new request until its result is loaded.
// A two-entry request queue and the result register let push and pop stall on their own.
// Reset (asynchronous, active low) clears the ring valid bits, counters, request queue
// and result valid flag and loads a window length of 20; no clearing pass is needed.
module rolling_standard_deviation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [rsd_pkg::SAMPLE_W-1:0] sample_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [rsd_pkg::STD_W-1:0]    std_dev_o,
  output logic                         window_full_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rsd_pkg::CFG_W-1:0]    cfg_data_i
);
  import rsd_pkg::*;

  logic  q_pop, q_empty;
  item_t q_item;

  rsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .sample_i   (sample_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_pop_i    (q_pop),
    .q_empty_o  (q_empty),
    .q_item_o   (q_item)
  );

  rsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .std_dev_o    (std_dev_o),
    .window_full_o(window_full_o)
  );

endmodule

// ===== rtl/rsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rsd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/rsd_front.sv =====
// Front end: config register, sample counter and the request queue to the back end.
module rsd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [rsd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rsd_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       q_pop_i,
  output logic                       q_empty_o,
  output rsd_pkg::item_t             q_item_o
);
  import rsd_pkg::*;

  logic [CFG_W-1:0]  cfg_q;
  logic [N_W-1:0]    seen_q, seen_d;
  logic [N_W-1:0]    n_eff;
  item_t             ent_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              acc, deq;
  item_t             new_item;

  assign cfg_ready_o = 1'b1;
  assign full        = (cnt_q == QCNT_W'(QDEPTH));
  assign q_empty_o   = (cnt_q == '0);
  assign q_item_o    = ent_q[rptr_q];
  assign acc         = push && !full;
  assign deq         = q_pop_i && !q_empty_o;

  // zero means one, anything past the ring depth means the full ring
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = N_W'(1);
    end else if (N_W'(cfg_q) > N_W'(WIN_MAX)) begin
      n_eff = N_W'(WIN_MAX);
    end else begin
      n_eff = N_W'(cfg_q);
    end
  end

  assign seen_d = (seen_q < N_W'(WIN_MAX)) ? seen_q + N_W'(1) : seen_q;

  always_comb begin
    new_item.sample = sample_i;
    new_item.n      = n_eff;
    new_item.full   = (seen_d >= n_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= WIN_RESET;
      seen_q <= '0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (acc) begin
        seen_q <= seen_d;
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (deq) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(acc) - QCNT_W'(deq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ent_q[wptr_q] <= new_item;
    end
  end

endmodule

// ===== rtl/rsd_back.sv =====
// Back end: sample ring, window sums, square root, divide and result register.
module rsd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  rsd_pkg::item_t              q_item_i,
  output logic                        q_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [rsd_pkg::STD_W-1:0]   std_dev_o,
  output logic                        window_full_o
);
  import rsd_pkg::*;

  back_state_e              state_q, state_d;
  item_t                    cur_q;
  logic [ADDR_W-1:0]        wp_q, base_q, raddr;
  logic [WIN_MAX-1:0]       vld_q;
  logic [N_W-1:0]           i_q;
  logic                     rd_pend_q, rd_ok_q, issue;
  logic [SAMPLE_W-1:0]      rdata, v;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]          sq_q;
  logic [2*SAMPLE_W-1:0]    prod;
  logic [SUM_W-1:0]         mag;
  logic [DEV_W-1:0]         nq_q, ss_q;
  logic [RAD_W-1:0]         rad_q;
  logic [ROOT_W+1:0]        rem_q, rem_w, trial;
  logic [ROOT_W-1:0]        root_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [N_W-1:0]           drem_q;
  logic [N_W:0]             dtrial, dsub;
  logic                     dge, out_vld_q, load;
  logic                     we;

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign we      = (state_q == ST_WRITE);
  assign issue   = (i_q < cur_q.n);
  assign raddr   = base_q - i_q[ADDR_W-1:0];
  assign v       = rd_ok_q ? rdata : '0;
  assign prod    = (2*SAMPLE_W)'($signed(v) * $signed(v));
  assign mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  rsd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WIN_MAX)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wp_q),
    .wdata_i(cur_q.sample),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // one root bit per cycle, restoring
  assign rem_w = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
  assign trial = {root_q, 2'b01};
  // one quotient bit per cycle, restoring
  assign dtrial = {drem_q, root_q[ROOT_W-1]};
  assign dge    = (dtrial >= {1'b0, cur_q.n});
  assign dsub   = dtrial - {1'b0, cur_q.n};

  assign load  = (state_q == ST_DONE) && (!out_vld_q || pop);
  assign empty = !out_vld_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!q_empty_i) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_SUM;
      ST_SUM:   if (!issue && !rd_pend_q) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUB;
      ST_SUB:   state_d = ST_SQRT;
      ST_SQRT:  if (cnt_q == CNT_W'(ROOT_W - 1)) state_d = ST_DIV;
      ST_DIV:   if (cnt_q == CNT_W'(ROOT_W - 1)) state_d = ST_DONE;
      ST_DONE:  if (load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      vld_q     <= '0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (we) begin
        wp_q        <= wp_q + ADDR_W'(1);
        vld_q[wp_q] <= 1'b1;
      end
      rd_pend_q <= (state_q == ST_SUM) && issue;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ok_q <= vld_q[raddr];
    unique case (state_q)
      ST_IDLE: begin
        cur_q <= q_item_i;
      end
      ST_WRITE: begin
        base_q <= wp_q;
        i_q    <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
      end
      ST_SUM: begin
        if (issue) begin
          i_q <= i_q + N_W'(1);
        end
        if (rd_pend_q) begin
          sum_q <= sum_q + SUM_W'($signed(v));
          sq_q  <= sq_q + SQ_W'(prod);
        end
      end
      ST_MUL: begin
        nq_q <= DEV_W'(cur_q.n) * DEV_W'(sq_q);
        ss_q <= DEV_W'(mag) * DEV_W'(mag);
      end
      ST_SUB: begin
        rad_q  <= {nq_q - ss_q, {FRAC_W{1'b0}}};
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end
      ST_SQRT: begin
        rad_q <= {rad_q[RAD_W-3:0], 2'b00};
        if (rem_w >= trial) begin
          rem_q  <= rem_w - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_w;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
        cnt_q  <= (cnt_q == CNT_W'(ROOT_W - 1)) ? '0 : cnt_q + CNT_W'(1);
        drem_q <= '0;
      end
      ST_DIV: begin
        drem_q <= dge ? dsub[N_W-1:0] : dtrial[N_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], dge};
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      ST_DONE: begin
        if (load) begin
          std_dev_o     <= (root_q > ROOT_W'(STD_MAX)) ? STD_MAX : root_q[STD_W-1:0];
          window_full_o <= cur_q.full;
        end
      end
      default: begin
        cur_q <= cur_q;
      end
    endcase
  end

endmodule

// ===== rtl/rsd_checker.sv =====
// Port-level checker for the rolling standard deviation block, bound to the top level.
`include "assert_macros.svh"

module rsd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [rsd_pkg::STD_W-1:0]    std_dev_o,
  input logic                         window_full_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o
);

  // a waiting result stays until popped
  `RSD_ASSERT(a_res_held, !empty && !pop |=> !empty)
  `RSD_ASSERT(a_res_stable, !empty && !pop |=> $stable(std_dev_o) && $stable(window_full_o))
  // the request queue only fills through a push
  `RSD_ASSERT(a_full_by_push, $rose(full) |-> $past(push))
  // the config channel never back-pressures
  `RSD_ASSERT(a_cfg_ready, cfg_valid_i |-> cfg_ready_o)

endmodule

bind rolling_standard_deviation rsd_checker u_rsd_checker (.*);

// ===== dv/tb_rolling_standard_deviation.sv =====
// Testbench for rolling_standard_deviation: queue-driven stimulus with a scoreboard.
`timescale 1ns / 1ps

module tb_rolling_standard_deviation;
  import rsd_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct {
    logic [STD_W-1:0] std_dev;
    logic             win_full;
  } dev_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [SAMPLE_W-1:0] sample_i;
  logic                empty;
  logic                pop;
  logic [STD_W-1:0]    std_dev_o;
  logic                window_full_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i;

  rolling_standard_deviation i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .sample_i     (sample_i),
    .empty        (empty),
    .pop          (pop),
    .std_dev_o    (std_dev_o),
    .window_full_o(window_full_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // Shadow copy of the block's window state
  logic signed [SAMPLE_W-1:0] shadow_ring [WIN_MAX];
  int unsigned                wr_pos;
  int unsigned                seen_cnt;
  logic [CFG_W-1:0]           win_len_reg;

  logic [SAMPLE_W-1:0] sample_queue [$];
  dev_result_t         expected_devs [$];
  int unsigned         fail_cnt;
  int unsigned         idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic dev_result_t window_deviation(input logic [SAMPLE_W-1:0] smp);
    dev_result_t     res;
    longint unsigned n;
    longint          sum;
    longint unsigned sq_sum;
    longint unsigned mag;
    longint unsigned dev;
    longint          v;
    int unsigned     idx;
    n = win_len_reg;
    if (n == 0) n = 1;
    if (n > WIN_MAX) n = WIN_MAX;
    shadow_ring[wr_pos] = smp;
    wr_pos = (wr_pos + 1) % WIN_MAX;
    if (seen_cnt < WIN_MAX) seen_cnt++;
    sum    = 0;
    sq_sum = 0;
    for (int unsigned i = 0; i < n; i++) begin
      idx    = (wr_pos + WIN_MAX - 1 - i) % WIN_MAX;
      v      = shadow_ring[idx];
      sum    = sum + v;
      sq_sum = sq_sum + longint'(v * v);
    end
    mag = (sum < 0) ? -sum : sum;
    dev = n * sq_sum - mag * mag;
    dev = int_sqrt(dev << 16) / n;
    res.std_dev  = (dev > STD_MAX) ? STD_MAX : dev[STD_W-1:0];
    res.win_full = (seen_cnt >= n);
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return SAMPLE_W'($urandom());
      1: return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return SAMPLE_W'($signed($urandom_range(0, 2000)) + 1000);
    endcase
  endfunction

  // Driver: bursts of requests separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        expected_devs.push_back(window_deviation(sample_i));
        void'(sample_queue.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      if (gap_left > 0 && !(push && full)) begin
        gap_left--;
        push <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        push     <= 1'b1;
        sample_i <= sample_queue[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor, result stall pattern and watchdog
  int unsigned pop_pct;
  int unsigned pat_cnt;
  always @(posedge clk_i) begin
    dev_result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_devs.size() == 0) begin
          $error("unexpected result: std_dev %0d window_full %0b", std_dev_o, window_full_o);
          fail_cnt++;
        end else begin
          want = expected_devs.pop_front();
          if (std_dev_o !== want.std_dev) begin
            $error("std_dev: expected %0d, got %0d", want.std_dev, std_dev_o);
            fail_cnt++;
          end
          if (window_full_o !== want.win_full) begin
            $error("window_full: expected %0b, got %0b", want.win_full, window_full_o);
            fail_cnt++;
          end
        end
      end
      if ((pop && !empty) || (push && !full) || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL rolling_standard_deviation");
        $finish;
      end
      pat_cnt++;
      if (pat_cnt % 97 == 0) begin
        case ($urandom_range(0, 3))
          0: pop_pct = 100;
          1: pop_pct = 50;
          2: pop_pct = 10;
          default: pop_pct = 2;
        endcase
      end
      pop <= ($urandom_range(0, 99) < pop_pct);
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i); while (sample_queue.size() > 0 || expected_devs.size() > 0);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] len);
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_len_reg = len;
  endtask

  initial begin
    logic [CFG_W-1:0] phase_len [8];
    phase_len   = '{7'd64, 7'd0, 7'd127, 7'd65, 7'd1, 7'd2, 7'd33, 7'd5};
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    sample_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    fail_cnt    = 0;
    idle_cycles = 0;
    burst_left  = 8;
    gap_left    = 0;
    pop_pct     = 100;
    pat_cnt     = 0;
    wr_pos      = 0;
    seen_cnt    = 0;
    win_len_reg = WIN_RESET;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Partial window at reset length: cleared slots count as zero samples
    sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'h7fff);
    sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'hffff);
    sample_queue.push_back(16'h0001);
    wait_drained();
    // Window length 64 with 16 samples of alternating extremes: the window is not yet full
    write_window(7'd64);
    for (int i = 0; i < 16; i++) sample_queue.push_back(i[0] ? 16'h8000 : 16'h7fff);

    for (int p = 0; p < 8; p++) begin
      write_window(phase_len[p]);
      for (int i = 0; i < 85; i++) sample_queue.push_back(pick_sample());
    end
    // Random length, changed without draining first is not allowed; drain then write
    write_window(CFG_W'($urandom_range(0, 127)));
    for (int i = 0; i < 20; i++) sample_queue.push_back(pick_sample());

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS rolling_standard_deviation");
    end else begin
      $display("FAIL rolling_standard_deviation");
    end
    $finish;
  end

endmodule
